// ===== hdl/fwbd_pkg.sv =====
// Shared types and constants for the flash write buffer with dedup commit.
// No dependencies; imported by the controller, datapath and top level.
package fwbd_pkg;

  localparam int unsigned PAGE_W  = 24;
  localparam int unsigned INDEX_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic append;
    logic scan_init;
    logic rd_issue;
    logic consume;
    logic emit;
    logic emit_last;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cand_vld;
    logic seen;
    logic pend_vld;
    logic rd_more;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/fwbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fwbd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fwbd_ctrl.sv =====
// Controller FSM: input handshake, append/commit decision, scan sequencing.
// Depends on fwbd_pkg (state, command and status types).
module fwbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fwbd_pkg::status_t status_i,
  output fwbd_pkg::cmd_t    cmd_o
);
  import fwbd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.full) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.consume  = status_i.cand_vld &
                         (status_i.seen | !status_i.pend_vld | status_i.out_free);
        cmd_o.emit     = cmd_o.consume & !status_i.seen & status_i.pend_vld;
        cmd_o.rd_issue = status_i.rd_more & (cmd_o.consume | !status_i.cand_vld);
        if (!status_i.rd_more && !status_i.cand_vld) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          cmd_o.restart   = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fwbd_datapath.sv =====
// Datapath: page store and fill count RAMs, dedup CAM, pending beat, output register.
// Depends on fwbd_pkg and fwbd_ram.
module fwbd_datapath #(
  parameter int unsigned NUM_BUFS         = 16,
  parameter int unsigned BUF_PAGES        = 64,
  parameter int unsigned PAGE_NUMBER_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [fwbd_pkg::PAGE_W-1:0]         page_number_i,
  input  fwbd_pkg::cmd_t                      cmd_i,
  output fwbd_pkg::status_t                   status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [fwbd_pkg::PAGE_W-1:0]         committed_page_o,
  output logic [fwbd_pkg::INDEX_W-1:0]        buffer_index_o,
  output logic                                last_o
);
  import fwbd_pkg::*;

  localparam int unsigned PW  = (PAGE_NUMBER_BITS < PAGE_W) ? PAGE_NUMBER_BITS : PAGE_W;
  localparam int unsigned SW  = $clog2(BUF_PAGES);
  localparam int unsigned BIW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int unsigned CW  = $clog2(BUF_PAGES + 1);
  localparam int unsigned PDEPTH = NUM_BUFS * BUF_PAGES;
  localparam int unsigned PAW = $clog2(PDEPTH);

  logic [PW-1:0]  in_pg;
  logic [31:0]    in_shift;
  logic [BIW-1:0] in_blk;

  logic [PW-1:0]  pg_q;
  logic [BIW-1:0] blk_q;

  logic [NUM_BUFS-1:0] fill_vld_q;
  logic [CW-1:0]  fill_rdata;
  logic [CW-1:0]  fill_cnt;
  logic           fill_we;
  logic [CW-1:0]  fill_wdata;

  logic [SW-1:0]  slot_q;
  logic           rd_more_q;
  logic           cand_vld_q;
  logic [PW-1:0]  cand;
  logic [SW-1:0]  wr_slot;

  logic [PW-1:0]        uniq_q [BUF_PAGES];
  logic [BUF_PAGES-1:0] uniq_vld_q;
  logic [BUF_PAGES-1:0] match;
  logic [CW-1:0]        ins_q;
  logic                 seen;
  logic                 insert;

  logic [PW-1:0]  pend_q;
  logic           pend_vld_q;

  logic           out_vld_q;
  logic [PW-1:0]  out_page_q;
  logic [BIW-1:0] out_blk_q;
  logic           out_last_q;
  logic           out_free;

  assign in_pg    = page_number_i[PW-1:0];
  assign in_shift = 32'(in_pg) >> SW;
  assign in_blk   = in_shift[BIW-1:0] & BIW'(NUM_BUFS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pg_q  <= in_pg;
      blk_q <= in_blk;
    end
  end

  // fill counts: RAM plus per-buffer valid bits, invalid reads as zero
  assign fill_cnt   = fill_vld_q[blk_q] ? fill_rdata : '0;
  assign fill_we    = cmd_i.append | cmd_i.restart;
  assign fill_wdata = cmd_i.append ? CW'(fill_cnt + CW'(1)) : CW'(1);

  fwbd_ram #(.WIDTH(CW), .DEPTH(NUM_BUFS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (blk_q),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (in_blk),
    .rdata_o (fill_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
    end else if (fill_we) begin
      fill_vld_q[blk_q] <= 1'b1;
    end
  end

  assign wr_slot = cmd_i.append ? fill_cnt[SW-1:0] : '0;

  fwbd_ram #(.WIDTH(PW), .DEPTH(PDEPTH)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (PAW'({blk_q, wr_slot})),
    .wdata_i (pg_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (PAW'({blk_q, slot_q})),
    .rdata_o (cand)
  );

  // scan read pointer, newest slot first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      rd_more_q  <= 1'b0;
      cand_vld_q <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        slot_q    <= SW'(BUF_PAGES - 1);
        rd_more_q <= 1'b1;
      end else if (cmd_i.rd_issue) begin
        if (slot_q == '0) begin
          rd_more_q <= 1'b0;
        end else begin
          slot_q <= slot_q - SW'(1);
        end
      end
      if (cmd_i.scan_init) begin
        cand_vld_q <= 1'b0;
      end else if (cmd_i.rd_issue) begin
        cand_vld_q <= 1'b1;
      end else if (cmd_i.consume) begin
        cand_vld_q <= 1'b0;
      end
    end
  end

  // dedup CAM: one compare lane per entry
  always_comb begin
    for (int k = 0; k < BUF_PAGES; k++) begin
      match[k] = uniq_vld_q[k] && (uniq_q[k] == cand);
    end
  end

  assign seen   = |match;
  assign insert = cmd_i.consume & !seen;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BUF_PAGES; k++) begin
      if (insert && ins_q == CW'(k)) begin
        uniq_q[k] <= cand;
      end
    end
    if (insert) begin
      pend_q <= cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uniq_vld_q <= '0;
      ins_q      <= '0;
      pend_vld_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      uniq_vld_q <= '0;
      ins_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (insert) begin
        for (int k = 0; k < BUF_PAGES; k++) begin
          if (ins_q == CW'(k)) begin
            uniq_vld_q[k] <= 1'b1;
          end
        end
        ins_q      <= ins_q + CW'(1);
        pend_vld_q <= 1'b1;
      end else if (cmd_i.emit_last) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // output register: a unique page is held back one step so the last can be marked
  assign out_free = !out_vld_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_last) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.emit_last) begin
      out_page_q <= pend_q;
      out_blk_q  <= blk_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign committed_page_o = PAGE_W'(out_page_q);
  assign buffer_index_o   = INDEX_W'(out_blk_q);
  assign last_o           = out_last_q;

  assign status_o.full     = (fill_cnt == CW'(BUF_PAGES));
  assign status_o.cand_vld = cand_vld_q;
  assign status_o.seen     = seen;
  assign status_o.pend_vld = pend_vld_q;
  assign status_o.rd_more  = rd_more_q;
  assign status_o.out_free = out_free;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.emit_last) |-> out_free)
    else $error("beat emitted while output register busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !status_o.full)
    else $error("append into a full buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.consume |-> cand_vld_q)
    else $error("consume without a candidate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_last |-> pend_vld_q)
    else $error("final beat without a pending page");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_q <= CW'(BUF_PAGES))
    else $error("dedup list overflow");

endmodule

// ===== hdl/flash_write_buffer_dedup_commit.sv =====
// Top level: flash write buffer with dedup on commit.
// Depends on fwbd_pkg, fwbd_ctrl, fwbd_datapath (which uses fwbd_ram).
//
//   channel | handshake                 | beat
//   --------+---------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o   | page_number_i
//   out     | out_valid_o / out_ready_i | committed_page_o, buffer_index_o, last_o
//
// Append: per page, accept, then fill count lookup from its RAM.
// Commit of a full buffer: one page store read per cycle, newest slot first,
// stalling while out_ready_i holds the output register.
// One page in flight at a time; in_ready_o is high only while idle.
// Reset clears the fill-count valid bits; no RAM clearing pass is needed.
module flash_write_buffer_dedup_commit #(
  parameter int unsigned NUM_BUFS         = 16,
  parameter int unsigned BUF_PAGES        = 64,
  parameter int unsigned PAGE_NUMBER_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fwbd_pkg::PAGE_W-1:0]  page_number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fwbd_pkg::PAGE_W-1:0]  committed_page_o,
  output logic [fwbd_pkg::INDEX_W-1:0] buffer_index_o,
  output logic                         last_o
);
  import fwbd_pkg::*;

  cmd_t    cmd;
  status_t status;

  fwbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fwbd_datapath #(
    .NUM_BUFS         (NUM_BUFS),
    .BUF_PAGES        (BUF_PAGES),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .page_number_i    (page_number_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .committed_page_o (committed_page_o),
    .buffer_index_o   (buffer_index_o),
    .last_o           (last_o)
  );

endmodule
